/* hdl/ppc_pkg.sv */
// Shared types and codes for the polynomial product convolver.
`default_nettype none
package ppc_pkg;

  localparam int COEF_W = 32;  // coefficient and sum width
  localparam int CIDX_W = 5;   // loaded coefficient index width
  localparam int PIDX_W = 6;   // product index width
  localparam int DEG_W  = 5;   // degree register width
  localparam int CFG_AW = 1;   // configuration register index width

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_AW-1:0] REG_DEGREE_A = 1'd0;
  localparam logic [CFG_AW-1:0] REG_DEGREE_B = 1'd1;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [PIDX_W-1:0]        prod_index;
    logic signed [COEF_W-1:0] prod_value;
    logic                     last;
  } out_item_t;

  // Bookkeeping that travels alongside the data through the cell row.
  typedef struct packed {
    logic              valid;
    logic [PIDX_W-1:0] index;
    logic              last;
  } tag_t;

  typedef struct packed {
    logic start;  // compute beat accepted
    logic adv;    // pipeline may move
  } ctrl_t;

endpackage
`default_nettype wire

/* hdl/ppc_cell.sv */
// One convolution cell: holds a coefficient of a, multiplies it by the broadcast b term.
`default_nettype none
module ppc_cell (
  input  wire logic                       clk,
  input  wire ppc_pkg::ctrl_t             ctrl,
  input  wire logic                       load_en,
  input  wire logic [ppc_pkg::COEF_W-1:0] load_val,
  input  wire logic                       mask,
  input  wire logic [ppc_pkg::COEF_W-1:0] x,
  input  wire logic [ppc_pkg::COEF_W-1:0] s_in,
  output logic      [ppc_pkg::COEF_W-1:0] s_out
);
  import ppc_pkg::*;

  logic [COEF_W-1:0] a_r;
  logic [COEF_W-1:0] p_r, p_nxt;
  logic [COEF_W-1:0] s_r;

  // Cells above the degree of a contribute nothing.
  assign p_nxt = mask ? COEF_W'(a_r * x) : '0;

  always_ff @(posedge clk) begin
    if (load_en) begin
      a_r <= load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      p_r <= '0;
      s_r <= '0;
    end else if (ctrl.adv) begin
      p_r <= p_nxt;
      s_r <= p_r + s_in;
    end
  end

  assign s_out = s_r;

endmodule
`default_nettype wire

/* hdl/ppc_feed.sv */
// Feeder: store of b, index sequencer and the tag pipeline that tracks the cell row.
`default_nettype none
module ppc_feed #(
  parameter int NCELL = 32,
  parameter int AW    = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ppc_pkg::ctrl_t             ctrl,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [ppc_pkg::COEF_W-1:0] wr_data,
  input  wire logic [ppc_pkg::PIDX_W-1:0] deg_b,
  input  wire logic [ppc_pkg::PIDX_W-1:0] top_idx,
  output logic      [ppc_pkg::COEF_W-1:0] x,
  output ppc_pkg::tag_t                   tag
);
  import ppc_pkg::*;

  localparam int TAG_DEPTH = 3;  // b read, product, sum

  logic [COEF_W-1:0] mem [NCELL];
  logic [COEF_W-1:0] rd_r;
  logic              zero_r;
  logic              feed_r;
  logic [PIDX_W-1:0] cnt_r;
  logic              use_b;
  logic [AW-1:0]     rd_addr;
  tag_t              tag_nxt;
  tag_t              tag_r [TAG_DEPTH];

  assign use_b   = feed_r && (cnt_r <= deg_b);
  assign rd_addr = use_b ? cnt_r[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.adv) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Terms of b past its degree enter the row as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= 1'b1;
    end else if (ctrl.start) begin
      zero_r <= 1'b1;
    end else if (ctrl.adv) begin
      zero_r <= !use_b;
    end
  end

  assign x = zero_r ? '0 : rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start) begin
      feed_r <= 1'b1;
      cnt_r  <= '0;
    end else if (ctrl.adv && feed_r) begin
      if (cnt_r == top_idx) begin
        feed_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + PIDX_W'(1);
      end
    end
  end

  always_comb begin
    tag_nxt.valid = feed_r;
    tag_nxt.index = cnt_r;
    tag_nxt.last  = (cnt_r == top_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAG_DEPTH; i++) begin
        tag_r[i] <= '0;
      end
    end else if (ctrl.adv) begin
      tag_r[0] <= tag_nxt;
      for (int i = 1; i < TAG_DEPTH; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  assign tag = tag_r[TAG_DEPTH-1];

endmodule
`default_nettype wire

/* hdl/polynomial_product_convolver.sv */
// Top level: schoolbook polynomial multiplier built from a row of convolution cells.
//
// Input channel (in_valid/in_ready/in_data) takes three kinds of beat:
//   load a  - writes one coefficient of a into the cell with that index,
//   load b  - writes one coefficient of b into the b store,
//   compute - emits c[0] .. c[degree_a+degree_b] on the output channel.
// Loads are accepted back to back while no compute is running. A load whose
// index lies past MAX_DEGREE is dropped.
// A compute beat clears the cell row and streams b into it, one term per
// cycle unless the output stalls; every cell multiplies its a coefficient by
// the broadcast term and adds into the partial sum handed on by its upper
// neighbor. c[0] leaves the output register first, then one coefficient per
// cycle unless stalled, the last flagged with last; in_ready drops until the
// last beat is taken. When a result is held and out_ready is low the whole
// row, sequencer and store read freeze, so no result is lost. The user writes
// degree registers through cfg_* only while idle; the block does not enforce
// this. Values above MAX_DEGREE act as MAX_DEGREE. Reset clears the degrees
// and the control state; coefficient storage is not cleared.
`default_nettype none
module polynomial_product_convolver #(
  parameter int MAX_DEGREE = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ppc_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ppc_pkg::out_item_t               out_data,
  input  wire logic                        cfg_we,
  input  wire logic [ppc_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [ppc_pkg::DEG_W-1:0]   cfg_wdata
);
  import ppc_pkg::*;

  // Indices are 5 bits wide, so no more than 32 cells are ever reachable.
  localparam int EFF_DEG = (MAX_DEGREE < 31) ? MAX_DEGREE : 31;
  localparam int NCELL   = EFF_DEG + 1;
  localparam int AW      = $clog2(NCELL);

  logic [DEG_W-1:0]  deg_a_r, deg_b_r;
  logic [PIDX_W-1:0] da_eff, db_eff, top_idx;
  logic              busy_r;
  logic              acc, start, ld_a, ld_b, adv;
  logic              out_valid_r;
  out_item_t         out_r;
  ctrl_t             ctrl;
  tag_t              tag;
  logic [COEF_W-1:0] x;
  logic [COEF_W-1:0] s_chain [NCELL+1];

  // Configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_a_r <= '0;
      deg_b_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGREE_A: deg_a_r <= cfg_wdata;
        REG_DEGREE_B: deg_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign da_eff  = ({1'b0, deg_a_r} > PIDX_W'(EFF_DEG)) ? PIDX_W'(EFF_DEG) : {1'b0, deg_a_r};
  assign db_eff  = ({1'b0, deg_b_r} > PIDX_W'(EFF_DEG)) ? PIDX_W'(EFF_DEG) : {1'b0, deg_b_r};
  assign top_idx = da_eff + db_eff;

  // Input decode.
  assign in_ready = !busy_r;
  assign acc      = in_valid && in_ready;
  assign start    = acc && (in_data.cmd == CMD_COMPUTE);
  assign ld_a     = acc && (in_data.cmd == CMD_LOAD_A);
  assign ld_b     = acc && (in_data.cmd == CMD_LOAD_B) &&
                    ({1'b0, in_data.coef_index} <= PIDX_W'(EFF_DEG));

  assign adv        = !out_valid_r || out_ready;
  assign ctrl.start = start;
  assign ctrl.adv   = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (out_valid_r && out_ready && out_r.last) begin
      busy_r <= 1'b0;
    end
  end

  ppc_feed #(
    .NCELL (NCELL),
    .AW    (AW)
  ) u_feed (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .wr_en   (ld_b),
    .wr_addr (in_data.coef_index[AW-1:0]),
    .wr_data (in_data.coef_value),
    .deg_b   (db_eff),
    .top_idx (top_idx),
    .x       (x),
    .tag     (tag)
  );

  // Partial sums flow from the highest cell down to cell 0.
  assign s_chain[NCELL] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ppc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_en  (ld_a && (in_data.coef_index == CIDX_W'(k))),
      .load_val (in_data.coef_value),
      .mask     (PIDX_W'(k) <= da_eff),
      .x        (x),
      .s_in     (s_chain[k+1]),
      .s_out    (s_chain[k])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && tag.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag.valid) begin
      out_r.prod_index <= tag.index;
      out_r.prod_value <= s_chain[0];
      out_r.last       <= tag.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r)
    else $error("result beat while no compute is running");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !out_valid_r)
    else $error("compute started with a stale result pending");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |-> out_r.prod_index == top_idx)
    else $error("last flag on wrong product index");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && out_r.last |=> !busy_r)
    else $error("block still busy after last beat");

endmodule
`default_nettype wire

/* tb/polynomial_product_convolver_tb.sv */
// Self-checking testbench for the polynomial product convolver.
`default_nettype none
module polynomial_product_convolver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppc_pkg::*;

  localparam int STORE_DEPTH  = 32;
  localparam int SETTLE_LIMIT = 12;   // cycles to let a compute finish before a cfg write
  localparam int RANDOM_ITEMS = 4;    // counted random load and compute beats per degree setting

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_AW-1:0]    cfg_index = '0;
  logic [DEG_W-1:0]     cfg_wdata = '0;

  // Predictor state
  logic signed [COEF_W-1:0] coef_a [STORE_DEPTH];
  logic signed [COEF_W-1:0] coef_b [STORE_DEPTH];
  bit                       coef_a_written [STORE_DEPTH];
  bit                       coef_b_written [STORE_DEPTH];
  int                       deg_a = 0;
  int                       deg_b = 0;
  out_item_t                pending_coefs [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int loads_sent     = 0;
  int products_sent  = 0;
  int coefs_checked  = 0;
  int settings_used  = 0;

  polynomial_product_convolver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic in_item_t make_beat(input logic [1:0] cmd, input int idx,
                                         input logic [COEF_W-1:0] val);
    in_item_t b;
    b.cmd        = cmd;
    b.coef_index = CIDX_W'(idx);
    b.coef_value = val;
    return b;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Expected product coefficients for the current stores and degrees.
  function automatic void predict_product();
    int top;
    logic [COEF_W-1:0] sum;
    out_item_t c;
    top = deg_a + deg_b;
    for (int j = 0; j <= top; j++) begin
      sum = '0;
      for (int k = 0; k <= j; k++) begin
        if (k <= deg_a && (j - k) <= deg_b) sum += coef_a[k] * coef_b[j-k];
      end
      c.prod_index = PIDX_W'(j);
      c.prod_value = sum;
      c.last       = (j == top);
      pending_coefs = {pending_coefs, c};
    end
  endfunction

  function automatic void apply_beat(input in_item_t b);
    case (b.cmd)
      CMD_LOAD_A: begin
        coef_a[b.coef_index]         = b.coef_value;
        coef_a_written[b.coef_index] = 1'b1;
        loads_sent++;
      end
      CMD_LOAD_B: begin
        coef_b[b.coef_index]         = b.coef_value;
        coef_b_written[b.coef_index] = 1'b1;
        loads_sent++;
      end
      CMD_COMPUTE: begin
        predict_product();
        products_sent++;
      end
      default: ;  // unused command: no effect
    endcase
  endfunction

  task automatic send_beat(input in_item_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    apply_beat(b);
  endtask

  // Hold off the sender until every expected coefficient has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE_LIMIT) @(posedge clk);
  endtask

  task automatic write_degrees(input int da, input int db);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEGREE_A;
    cfg_wdata <= DEG_W'(da);
    @(posedge clk);
    cfg_index <= REG_DEGREE_B;
    cfg_wdata <= DEG_W'(db);
    @(posedge clk);
    cfg_we <= 1'b0;
    deg_a = da;
    deg_b = db;
    settings_used++;
  endtask

  // Load every entry the next compute will read: all of them on reload, else those not yet written.
  task automatic fill_degrees(input bit reload);
    for (int i = 0; i <= deg_a; i++)
      if (reload || !coef_a_written[i]) send_beat(make_beat(CMD_LOAD_A, i, rand_coef()));
    for (int i = 0; i <= deg_b; i++)
      if (reload || !coef_b_written[i]) send_beat(make_beat(CMD_LOAD_B, i, rand_coef()));
  endtask

  task automatic check_coef(input out_item_t got);
    out_item_t want;
    if (pending_coefs.size() == 0) begin
      report_mismatch($sformatf("unexpected coefficient index %0d value %0h",
                                got.prod_index, got.prod_value));
      return;
    end
    want = pending_coefs.pop_front();
    coefs_checked++;
    if (got.prod_index !== want.prod_index)
      report_mismatch($sformatf("prod_index got %0d want %0d", got.prod_index,
                                want.prod_index));
    if (got.prod_value !== want.prod_value)
      report_mismatch($sformatf("c[%0d] got %0h want %0h", want.prod_index,
                                got.prod_value, want.prod_value));
    if (got.last !== want.last)
      report_mismatch($sformatf("c[%0d] last got %b want %b", want.prod_index,
                                got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) check_coef(out_data);
    end
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_degrees(0, 0);
    send_beat(make_beat(CMD_LOAD_A, 0, 32'h8000_0000));
    send_beat(make_beat(CMD_LOAD_B, 0, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_COMPUTE, 0, '0));
    // unused command and ignored fields on compute
    send_beat(make_beat(CMD_UNUSED, 31, 32'hDEAD_BEEF));
    send_beat(make_beat(CMD_COMPUTE, 31, 32'hFFFF_FFFF));
    // stored past the degree, must not contribute yet
    send_beat(make_beat(CMD_LOAD_A, 31, 32'h7FFF_FFFF));
    send_beat(make_beat(CMD_LOAD_B, 31, 32'h5555_5555));
    send_beat(make_beat(CMD_COMPUTE, 0, '0));
    wait_drained();
    write_degrees(2, 1);
    send_beat(make_beat(CMD_LOAD_A, 1, 32'h7FFF_FFFF));
    send_beat(make_beat(CMD_LOAD_A, 2, 32'h0000_0001));
    send_beat(make_beat(CMD_LOAD_B, 1, 32'h7FFF_FFFF));
    send_beat(make_beat(CMD_COMPUTE, 0, '0));
    send_beat(make_beat(CMD_LOAD_B, 0, 32'h0000_0000));
    send_beat(make_beat(CMD_COMPUTE, 0, '0));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int first_da, input int first_db);
    int da, db, items, r, idx;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int s = 0; s < 3; s++) begin
      if (s == 0) begin
        da = first_da;
        db = first_db;
      end else if ($urandom_range(4) == 0) begin
        da = $urandom_range(31);
        db = $urandom_range(31);
      end else begin
        da = $urandom_range(6);
        db = $urandom_range(6);
      end
      wait_drained();
      write_degrees(da, db);
      fill_degrees($urandom_range(2) == 0);
      items = 0;
      while (items < RANDOM_ITEMS) begin
        r = $urandom_range(99);
        if (r < 8) begin
          send_beat(make_beat(CMD_UNUSED, $urandom_range(31), $urandom));
        end else if (r < 30) begin
          send_beat(make_beat(CMD_COMPUTE, $urandom_range(31), $urandom));
          items++;
        end else if (r < 65) begin
          idx = ($urandom_range(9) < 7) ? $urandom_range(deg_a) : $urandom_range(31);
          send_beat(make_beat(CMD_LOAD_A, idx, rand_coef()));
          items++;
        end else begin
          idx = ($urandom_range(9) < 7) ? $urandom_range(deg_b) : $urandom_range(31);
          send_beat(make_beat(CMD_LOAD_B, idx, rand_coef()));
          items++;
        end
      end
      send_beat(make_beat(CMD_COMPUTE, 0, '0));
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(6, 61, 31, 0);
    test_random_traffic(61, 6, 0, 31);
    test_random_traffic(0, 0, 31, 31);
    $display("Covered %0d coefficient loads and %0d products, %0d coefficients checked,",
             loads_sent, products_sent, coefs_checked);
    $display("over %0d degree settings from 0 up to 31 with and without back-pressure.",
             settings_used);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d coefficients still expected", pending_coefs.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
